// ----- hdl/wpd_pkg.sv -----
package wpd_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned LaneDepth = 4;
  localparam int unsigned Latency   = 2 + LaneDepth + SqrtSteps;

  localparam logic [18:0] TwoPiQ16 = 19'd411775;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WEIGHT_X       = 3'd0,
    REG_WEIGHT_Y       = 3'd1,
    REG_WEIGHT_HEADING = 3'd2,
    REG_INV_X          = 3'd3,
    REG_INV_Y          = 3'd4,
    REG_INV_HEADING    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] weight_x;
    logic [31:0] weight_y;
    logic [31:0] weight_heading;
    logic [31:0] inv_interval_x;
    logic [31:0] inv_interval_y;
    logic [31:0] inv_interval_heading;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    weight_x:             32'd65536,
    weight_y:             32'd65536,
    weight_heading:       32'd65536,
    inv_interval_x:       32'd65536,
    inv_interval_y:       32'd65536,
    inv_interval_heading: 32'd10430
  };

  typedef struct packed {
    logic signed [31:0] first_pos_x;
    logic signed [31:0] first_pos_y;
    logic        [18:0] first_heading;
    logic signed [31:0] second_pos_x;
    logic signed [31:0] second_pos_y;
    logic        [18:0] second_heading;
  } req_t;

  typedef struct packed {
    logic [31:0] distance;
    logic        saturated;
  } res_t;

endpackage

// ----- hdl/weighted_pose_distance.sv -----
// Throughput: one request per cycle; busy stays low and the receiver cannot stall.
// Depth is set by an input stage, four multiplier stages per axis lane, a summing
// stage and a 32-stage square-root pipeline that settles one root bit per stage.
// Reset is asynchronous: it drops requests in flight and restores defaults.
module weighted_pose_distance
  import wpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  req_t               req_i,
  output logic               res_valid_o,
  output res_t               res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i
);

  cfg_t        cfg;
  logic        accept;

  logic [32:0] dx_diff, dy_diff, dx_mag, dy_mag;
  logic [18:0] dh, alt, wh;

  logic        s1_vld_q;
  logic [32:0] mx_q, my_q;
  logic [18:0] mh_q;

  logic        vx, vy, vh;
  logic [63:0] tx, ty, th;
  logic        ox, oy, oh;

  logic [65:0] sum_full;
  logic        sum_sat;
  logic        s6_vld_q;
  logic [63:0] sum_q;
  logic        sat_q;

  logic [31:0] root;
  logic        root_sat;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  wpd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  always_comb begin
    dx_diff = {req_i.first_pos_x[31], req_i.first_pos_x}
            - {req_i.second_pos_x[31], req_i.second_pos_x};
    dy_diff = {req_i.first_pos_y[31], req_i.first_pos_y}
            - {req_i.second_pos_y[31], req_i.second_pos_y};
    dx_mag  = dx_diff[32] ? (~dx_diff + 33'd1) : dx_diff;
    dy_mag  = dy_diff[32] ? (~dy_diff + 33'd1) : dy_diff;
    dh      = (req_i.first_heading >= req_i.second_heading)
            ? (req_i.first_heading - req_i.second_heading)
            : (req_i.second_heading - req_i.first_heading);
    alt     = (dh <= TwoPiQ16) ? (TwoPiQ16 - dh) : (dh - TwoPiQ16);
    wh      = (dh < alt) ? dh : alt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s6_vld_q <= vx & vy & vh;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q  <= dx_mag;
    my_q  <= dy_mag;
    mh_q  <= wh;
    sum_q <= sum_sat ? 64'hFFFF_FFFF_FFFF_FFFF : sum_full[63:0];
    sat_q <= sum_sat;
  end

  wpd_axis_term u_term_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_vld_q),
    .mag_i    (mx_q),
    .inv_i    (cfg.inv_interval_x),
    .weight_i (cfg.weight_x),
    .valid_o  (vx),
    .term_o   (tx),
    .ovf_o    (ox)
  );

  wpd_axis_term u_term_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_vld_q),
    .mag_i    (my_q),
    .inv_i    (cfg.inv_interval_y),
    .weight_i (cfg.weight_y),
    .valid_o  (vy),
    .term_o   (ty),
    .ovf_o    (oy)
  );

  wpd_axis_term u_term_h (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_vld_q),
    .mag_i    ({14'd0, mh_q}),
    .inv_i    (cfg.inv_interval_heading),
    .weight_i (cfg.weight_heading),
    .valid_o  (vh),
    .term_o   (th),
    .ovf_o    (oh)
  );

  always_comb begin
    sum_full = {2'b00, tx} + {2'b00, ty} + {2'b00, th};
    sum_sat  = ox | oy | oh | (|sum_full[65:64]);
  end

  wpd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s6_vld_q),
    .sum_i   (sum_q),
    .sat_i   (sat_q),
    .valid_o (res_valid_o),
    .root_o  (root),
    .sat_o   (root_sat)
  );

  assign res_o.distance  = root;
  assign res_o.saturated = root_sat;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start, Latency))
    else $error("result strobe without a request at the pipeline depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vx || vy || vh) |-> (vx && vy && vh))
    else $error("axis lanes out of step");

endmodule

// ----- hdl/wpd_cfg_regs.sv -----
module wpd_cfg_regs
  import wpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WEIGHT_X:       cfg_d.weight_x             = cfg_wdata_i;
        REG_WEIGHT_Y:       cfg_d.weight_y             = cfg_wdata_i;
        REG_WEIGHT_HEADING: cfg_d.weight_heading       = cfg_wdata_i;
        REG_INV_X:          cfg_d.inv_interval_x       = cfg_wdata_i;
        REG_INV_Y:          cfg_d.inv_interval_y       = cfg_wdata_i;
        REG_INV_HEADING:    cfg_d.inv_interval_heading = cfg_wdata_i;
        default:            cfg_d                      = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  // A write to an index beyond the register list changes nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_idx_i > REG_INV_HEADING)) |=> (cfg_o == $past(cfg_o)))
    else $error("write to unknown register index changed the configuration");

endmodule

// ----- hdl/wpd_axis_term.sv -----
module wpd_axis_term
  import wpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [32:0] mag_i,
  input  logic [31:0] inv_i,
  input  logic [31:0] weight_i,
  output logic        valid_o,
  output logic [63:0] term_o,
  output logic        ovf_o
);

  logic [LaneDepth-1:0] vld_q;

  logic [64:0] scaled;
  logic [31:0] norm_q;
  logic        ovf_n_q;

  logic [63:0] sq_q;
  logic        ovf_s_q;

  logic [63:0] hi_q, lo_q;
  logic        ovf_p_q;

  logic [79:0] wterm;
  logic [63:0] term_q;
  logic        ovf_t_q;

  always_comb begin
    scaled = {1'b0, 64'(mag_i[31:0] * inv_i)} + (mag_i[32] ? {1'b0, inv_i, 32'd0} : 65'd0);
    wterm  = {hi_q, 16'd0} + {32'd0, lo_q[63:16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LaneDepth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    norm_q  <= scaled[47:16];
    ovf_n_q <= |scaled[64:48];
    sq_q    <= 64'(norm_q * norm_q);
    ovf_s_q <= ovf_n_q;
    hi_q    <= 64'(sq_q[63:32] * weight_i);
    lo_q    <= 64'(sq_q[31:0] * weight_i);
    ovf_p_q <= ovf_s_q;
    term_q  <= wterm[63:0];
    ovf_t_q <= ovf_p_q | (|wterm[79:64]);
  end

  assign valid_o = vld_q[LaneDepth-1];
  assign term_o  = term_q;
  assign ovf_o   = ovf_t_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, LaneDepth))
    else $error("axis term valid out of step with its input");

endmodule

// ----- hdl/wpd_isqrt.sv -----
module wpd_isqrt
  import wpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] sum_i,
  input  logic        sat_i,
  output logic        valid_o,
  output logic [31:0] root_o,
  output logic        sat_o
);

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sqrt_st_t;

  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [63:0] b);
    sqrt_st_t    o;
    logic [63:0] trial;
    trial = s.root + b;
    if (s.rem >= trial) begin
      o.rem  = s.rem - trial;
      o.root = (s.root >> 1) + b;
    end else begin
      o.rem  = s.rem;
      o.root = s.root >> 1;
    end
    return o;
  endfunction

  sqrt_st_t             st_q [SqrtSteps];
  sqrt_st_t             st_d [SqrtSteps];
  logic [SqrtSteps-1:0] vld_q;
  logic [SqrtSteps-1:0] sat_q;

  always_comb begin
    st_d[0] = sqrt_step('{rem: sum_i, root: 64'd0}, 64'd1 << 62);
    for (int k = 1; k < SqrtSteps; k++) begin
      st_d[k] = sqrt_step(st_q[k-1], 64'd1 << (62 - 2 * k));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SqrtSteps-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= {sat_q[SqrtSteps-2:0], sat_i};
    for (int k = 0; k < SqrtSteps; k++) begin
      st_q[k] <= st_d[k];
    end
  end

  assign valid_o = vld_q[SqrtSteps-1];
  assign root_o  = st_q[SqrtSteps-1].root[31:0];
  assign sat_o   = sat_q[SqrtSteps-1];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, SqrtSteps))
    else $error("square root valid out of step with its input");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && sat_o) |-> (root_o == 32'hFFFF_FFFF))
    else $error("clamped sum did not give an all-ones root");

endmodule
